[hdl/cts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package cts_pkg;

   localparam int NUM_SLOTS   = 8;
   localparam int TICK_BITS   = 32;
   localparam int MAX_RESULTS = 8;
   localparam int SLOT_BITS   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);

   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_ADD      = 2'd1;
   localparam logic [1:0] OP_DELETE   = 2'd2;
   localparam logic [1:0] OP_DISPATCH = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;
   localparam logic [1:0] STATUS_NONE  = 2'd3;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_FULL   = 2'd1;
   localparam logic [1:0] ERR_DELETE = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [2:0]  task_slot;
      logic [31:0] first_delay;
      logic [31:0] repeat_period;
      logic [7:0]  task_tag;
   } req_word_type;

   typedef struct packed {
      logic [3:0] result_slot;
      logic [7:0] result_tag;
      logic [1:0] status;
      logic       run_valid;
      logic [1:0] sticky_error;
      logic       last_result;
   } rsp_word_type;

   typedef struct packed {
      logic                 in_use;
      logic [7:0]           task_tag;
      logic [TICK_BITS-1:0] countdown;
      logic [TICK_BITS-1:0] period;
      logic [7:0]           pending;
   } slot_type;

   // what the head stage saw on the slot passing it
   typedef struct packed {
      logic add_take;
      logic del_hit;
      logic del_used;
      logic run_hit;
   } head_event_type;

endpackage
`default_nettype wire

[hdl/cts_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module cts_cell (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic shift,
   input  cts_pkg::slot_type  entry_in,
   output cts_pkg::slot_type  entry_out
);

   cts_pkg::slot_type entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else if (shift) begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;

endmodule
`default_nettype wire

[hdl/cts_head.sv]
`timescale 1ns / 1ps
`default_nettype none
module cts_head (
   input  cts_pkg::req_word_type        cmd,
   input  cts_pkg::slot_type            entry_in,
   input  wire logic [cts_pkg::SLOT_BITS-1:0] step,
   input  wire logic                    found,
   input  wire logic                    run_ok,
   output cts_pkg::slot_type            entry_out,
   output cts_pkg::head_event_type      event_out
);

   always_comb begin
      entry_out = entry_in;
      event_out = '0;
      case (cmd.operation)
         cts_pkg::OP_TICK: begin
            if (entry_in.in_use) begin
               if (entry_in.countdown == '0) begin
                  if (entry_in.pending != 8'hFF) entry_out.pending = entry_in.pending + 8'd1;
                  entry_out.countdown = entry_in.period;
               end else begin
                  entry_out.countdown = entry_in.countdown - 1'b1;
               end
            end
         end
         cts_pkg::OP_ADD: begin
            if (!found && !entry_in.in_use) begin
               event_out.add_take  = 1'b1;
               entry_out.in_use    = 1'b1;
               entry_out.task_tag  = cmd.task_tag;
               entry_out.countdown = cts_pkg::TICK_BITS'(cmd.first_delay);
               entry_out.period    = cts_pkg::TICK_BITS'(cmd.repeat_period);
               entry_out.pending   = '0;
            end
         end
         cts_pkg::OP_DELETE: begin
            if (32'(step) == 32'(cmd.task_slot)) begin
               event_out.del_hit  = 1'b1;
               event_out.del_used = entry_in.in_use;
               entry_out          = '0;
            end
         end
         default: begin
            if (entry_in.pending != '0 && run_ok) begin
               event_out.run_hit = 1'b1;
               // one-shot tasks leave the table once they run
               if (entry_in.period == '0) begin
                  entry_out = '0;
               end else begin
                  entry_out.pending = entry_in.pending - 8'd1;
               end
            end
         end
      endcase
   end

endmodule
`default_nettype wire

[hdl/cooperative_task_scheduler_table_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Task scheduler table: a ring of slot cells rotates once past a single
// head update stage for every command word; the ring holds while the
// response side stalls a waiting run. Tick ages every slot in use, add
// fills the lowest free slot, delete clears one slot, and dispatch
// returns one response per slot with pending runs, in slot order (or a
// single none response if there is no such slot), with last_result set
// on the final response of the word. The table is empty right after
// reset; no clearing pass is needed.
module cooperative_task_scheduler_table_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  cts_pkg::req_word_type  req_word,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output cts_pkg::rsp_word_type  rsp_word
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam logic [cts_pkg::SLOT_BITS-1:0] LAST_STEP =
      cts_pkg::SLOT_BITS'(cts_pkg::NUM_SLOTS - 1);

   logic [1:0]                      state_ff, state_in;
   logic [cts_pkg::SLOT_BITS-1:0]   step_ff, step_in;
   cts_pkg::req_word_type           cmd_ff, cmd_in;
   logic                            found_ff, found_in;
   logic [cts_pkg::SLOT_BITS-1:0]   found_slot_ff, found_slot_in;
   logic                            used_ff, used_in;
   logic                            held_valid_ff, held_valid_in;
   logic [cts_pkg::SLOT_BITS-1:0]   held_slot_ff, held_slot_in;
   logic [7:0]                      held_tag_ff, held_tag_in;
   logic [cts_pkg::CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [1:0]                      err_ff, err_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   cts_pkg::rsp_word_type           rsp_ff, rsp_in;

   cts_pkg::slot_type               ring_q [cts_pkg::NUM_SLOTS];
   cts_pkg::slot_type               head_new;
   cts_pkg::head_event_type         head_ev;
   logic                            shift;
   logic                            out_free;
   logic                            run_ok;
   logic                            target_valid;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign run_ok       = 32'(cnt_ff) < 32'(cts_pkg::MAX_RESULTS);
   assign target_valid = 32'(cmd_ff.task_slot) < 32'(cts_pkg::NUM_SLOTS);

   cts_head u_head (
      .cmd       (cmd_ff),
      .entry_in  (ring_q[0]),
      .step      (step_ff),
      .found     (found_ff),
      .run_ok    (run_ok),
      .entry_out (head_new),
      .event_out (head_ev)
   );

   for (genvar i = 0; i < cts_pkg::NUM_SLOTS; i++) begin : g_ring
      if (i == cts_pkg::NUM_SLOTS - 1) begin : g_tail
         cts_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift     (shift),
            .entry_in  (head_new),
            .entry_out (ring_q[i])
         );
      end else begin : g_mid
         cts_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift     (shift),
            .entry_in  (ring_q[i+1]),
            .entry_out (ring_q[i])
         );
      end
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cmd_in        = cmd_ff;
      found_in      = found_ff;
      found_slot_in = found_slot_ff;
      used_in       = used_ff;
      held_valid_in = held_valid_ff;
      held_slot_in  = held_slot_ff;
      held_tag_in   = held_tag_ff;
      cnt_in        = cnt_ff;
      err_in        = err_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      shift         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_word;
               step_in       = '0;
               found_in      = 1'b0;
               found_slot_in = '0;
               used_in       = 1'b0;
               held_valid_in = 1'b0;
               cnt_in        = '0;
               state_in      = ST_RUN;
            end
         end
         ST_RUN: begin
            // hold the ring while an earlier run waits for the output
            if (!(head_ev.run_hit && held_valid_ff && !out_free)) begin
               shift = 1'b1;
               if (head_ev.run_hit) begin
                  if (held_valid_ff) begin
                     rsp_valid_in         = 1'b1;
                     rsp_in.result_slot   = 4'(held_slot_ff);
                     rsp_in.result_tag    = held_tag_ff;
                     rsp_in.status        = cts_pkg::STATUS_OK;
                     rsp_in.run_valid     = 1'b1;
                     rsp_in.sticky_error  = err_ff;
                     rsp_in.last_result   = 1'b0;
                  end
                  held_valid_in = 1'b1;
                  held_slot_in  = step_ff;
                  held_tag_in   = ring_q[0].task_tag;
                  cnt_in        = cnt_ff + 1'b1;
               end
               if (head_ev.add_take) begin
                  found_in      = 1'b1;
                  found_slot_in = step_ff;
               end
               if (head_ev.del_hit) used_in = head_ev.del_used;
               if (step_ff == LAST_STEP) begin
                  state_in = ST_DONE;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.result_slot = '0;
               rsp_in.result_tag  = '0;
               rsp_in.status      = cts_pkg::STATUS_OK;
               rsp_in.run_valid   = 1'b0;
               rsp_in.last_result = 1'b1;
               case (cmd_ff.operation)
                  cts_pkg::OP_ADD: begin
                     if (found_ff) begin
                        rsp_in.result_slot = 4'(found_slot_ff);
                     end else begin
                        err_in             = cts_pkg::ERR_FULL;
                        rsp_in.result_slot = 4'(cts_pkg::NUM_SLOTS);
                        rsp_in.status      = cts_pkg::STATUS_FULL;
                     end
                  end
                  cts_pkg::OP_DELETE: begin
                     rsp_in.result_slot = 4'(cmd_ff.task_slot);
                     if (!(target_valid && used_ff)) begin
                        err_in        = cts_pkg::ERR_DELETE;
                        rsp_in.status = cts_pkg::STATUS_EMPTY;
                     end
                  end
                  cts_pkg::OP_DISPATCH: begin
                     if (held_valid_ff) begin
                        rsp_in.result_slot = 4'(held_slot_ff);
                        rsp_in.result_tag  = held_tag_ff;
                        rsp_in.run_valid   = 1'b1;
                     end else begin
                        rsp_in.status = cts_pkg::STATUS_NONE;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_in.sticky_error = err_in;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         err_ff       <= cts_pkg::ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      cmd_ff        <= cmd_in;
      found_ff      <= found_in;
      found_slot_ff <= found_slot_in;
      used_ff       <= used_in;
      held_valid_ff <= held_valid_in;
      held_slot_ff  <= held_slot_in;
      held_tag_ff   <= held_tag_in;
      cnt_ff        <= cnt_in;
      rsp_ff        <= rsp_in;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_run_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.run_valid |-> rsp_word.status == cts_pkg::STATUS_OK)
      else $error("run word carries a non-ok status");

   a_full_err : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == cts_pkg::STATUS_FULL
      |-> rsp_word.sticky_error == cts_pkg::ERR_FULL
          && rsp_word.result_slot == 4'(cts_pkg::NUM_SLOTS))
      else $error("table full word without matching error and slot");

   a_multi_is_run : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.last_result |-> rsp_word.run_valid)
      else $error("non-final word that is not a dispatched run");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("new word taken while the ring is busy");

endmodule
`default_nettype wire
